// File: rtl/assert_macros.svh
// shared assertion macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every rising clock edge outside reset
`define CHK_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// implication whose consequent is checked in the cycle after the antecedent
`define CHK_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/efq_pkg.sv
package efq_pkg;

  typedef enum logic [2:0] {
    KIND_PUSH   = 3'd0,
    KIND_NOTICE = 3'd1,
    KIND_READ   = 3'd2,
    KIND_CLOSE  = 3'd3,
    KIND_POLL   = 3'd4
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_CLOSED      = 3'd1,
    ST_TOO_BIG     = 3'd2,
    ST_NO_SPACE    = 3'd3,
    ST_WOULD_BLOCK = 3'd4,
    ST_SMALL       = 3'd5
  } status_t;

  localparam logic [1:0] CFG_QUEUE_LIMIT   = 2'd0;
  localparam logic [1:0] CFG_PAYLOAD_LIMIT = 2'd1;
  localparam logic [1:0] CFG_DROP_TYPE     = 2'd2;
  localparam logic [1:0] CFG_DROP_FLAGS    = 2'd3;

  // controller -> datapath commands
  typedef struct packed {
    logic latch_req;   // capture input item, evaluate push/notice/close
    logic emit_drop;   // present coalesced drop record
    logic emit_entry;  // present head entry
    logic emit_done;   // present completion
    logic fetch;       // start memory read of head entry
  } efq_cmd_t;

  // datapath -> controller status
  typedef struct packed {
    logic       is_read;
    logic       space_zero;
    logic       has_drops;
    logic       has_entries;
    logic       closed;
    logic       drop_fits;
    logic       entry_fits;
    logic       copied_zero;
  } efq_stat_t;

endpackage

// File: rtl/event_fifo_with_drop_records.sv
// Bounded event queue with a coalesced drop record. Each request (push, drop
// notice, read, close, poll) gives zero or more records and then one completion
// marked by last. Push, notice, close and poll go from evaluation straight to
// the completion; a read gives the drop record, then each stored entry, fetched
// by the registered read of the entry memory, until space or entries run out or
// one does not fit. Any result is held while out_stall is high.
// Requests are refused (stall high) until the completion is taken. Configuration
// writes are taken at any time but belong in idle time.
module event_fifo_with_drop_records #(
  parameter int DEPTH = 16,
  parameter int MAX_PAYLOAD_BYTES = 8,
  parameter int HEADER_BYTES = 24,
  parameter int DROP_INFO_BYTES = 24
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  kind,
  input  logic [15:0] event_type,
  input  logic [15:0] event_flags,
  input  logic [7:0]  event_len,
  input  logic [63:0] payload_word,
  input  logic [15:0] read_space,
  input  logic [63:0] time_now,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        is_record,
  output logic [15:0] record_type,
  output logic [15:0] record_flags,
  output logic [7:0]  record_len,
  output logic [63:0] record_seq,
  output logic [63:0] record_time,
  output logic [63:0] record_payload,
  output logic [63:0] drop_last_seq,
  output logic [2:0]  status,
  output logic [15:0] bytes_copied,
  output logic [1:0]  availability,
  output logic        last
);
  import efq_pkg::*;

  efq_cmd_t  cmd;
  efq_stat_t stat;

  assign cfg_ready = 1'b1;

  efq_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .out_stall(out_stall), .out_valid(out_valid), .stat(stat), .cmd(cmd)
  );

  efq_dp #(
    .DEPTH(DEPTH), .MAX_PAYLOAD_BYTES(MAX_PAYLOAD_BYTES),
    .HEADER_BYTES(HEADER_BYTES), .DROP_INFO_BYTES(DROP_INFO_BYTES)
  ) u_dp (
    .clk(clk), .rst(rst), .cfg_valid(cfg_valid && cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .kind(kind), .event_type(event_type), .event_flags(event_flags),
    .event_len(event_len), .payload_word(payload_word), .read_space(read_space),
    .time_now(time_now), .cmd(cmd), .stat(stat), .is_record(is_record),
    .record_type(record_type), .record_flags(record_flags), .record_len(record_len),
    .record_seq(record_seq), .record_time(record_time), .record_payload(record_payload),
    .drop_last_seq(drop_last_seq), .status(status), .bytes_copied(bytes_copied),
    .availability(availability), .last(last)
  );
endmodule

// File: rtl/efq_ram.sv
module efq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// File: rtl/efq_ctrl.sv
module efq_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              out_stall,
  output logic              out_valid,
  input  efq_pkg::efq_stat_t stat,
  output efq_pkg::efq_cmd_t  cmd
);
  import efq_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_EVAL, S_FETCH, S_ENTRY, S_OUT, S_DONE} state_t;
  state_t state;
  logic   out_done;  // current shown result is the completion
  logic   take;

  assign in_stall = (state != S_IDLE);
  assign take     = out_valid && !out_stall;

  always_comb begin
    cmd = '0;
    cmd.latch_req = (state == S_IDLE) && in_valid;
    case (state)
      S_EVAL: begin
        if (!stat.is_read || stat.space_zero || (!stat.has_drops && !stat.has_entries))
          cmd.emit_done = 1'b1;
        else if (stat.has_drops) begin
          if (stat.drop_fits) cmd.emit_drop = 1'b1;
          else cmd.emit_done = 1'b1;
        end else cmd.fetch = 1'b1;
      end
      S_FETCH: cmd.fetch = 1'b0;
      S_ENTRY: begin
        if (stat.entry_fits) cmd.emit_entry = 1'b1;
        else cmd.emit_done = 1'b1;
      end
      S_OUT: begin
        if (take && !out_done) begin
          if (!stat.space_zero && stat.has_entries) cmd.fetch = 1'b1;
          else cmd.emit_done = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      out_done  <= 1'b0;
    end else begin
      case (state)
        S_IDLE:  if (in_valid) state <= S_EVAL;
        S_EVAL, S_ENTRY: begin
          if (cmd.fetch) state <= S_FETCH;
          else begin
            state     <= S_OUT;
            out_valid <= 1'b1;
            out_done  <= cmd.emit_done;
          end
        end
        S_FETCH: state <= S_ENTRY;
        S_OUT: begin
          if (take) begin
            if (out_done) begin
              out_valid <= 1'b0;
              state     <= S_IDLE;
            end else if (cmd.fetch) begin
              out_valid <= 1'b0;
              state     <= S_FETCH;
            end else begin
              out_done <= 1'b1;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// File: rtl/efq_dp.sv
module efq_dp #(
  parameter int DEPTH = 16,
  parameter int MAX_PAYLOAD_BYTES = 8,
  parameter int HEADER_BYTES = 24,
  parameter int DROP_INFO_BYTES = 24
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_valid,
  input  logic [1:0]        cfg_index,
  input  logic [15:0]       cfg_data,
  input  logic [2:0]        kind,
  input  logic [15:0]       event_type,
  input  logic [15:0]       event_flags,
  input  logic [7:0]        event_len,
  input  logic [63:0]       payload_word,
  input  logic [15:0]       read_space,
  input  logic [63:0]       time_now,
  input  efq_pkg::efq_cmd_t  cmd,
  output efq_pkg::efq_stat_t stat,
  output logic              is_record,
  output logic [15:0]       record_type,
  output logic [15:0]       record_flags,
  output logic [7:0]        record_len,
  output logic [63:0]       record_seq,
  output logic [63:0]       record_time,
  output logic [63:0]       record_payload,
  output logic [63:0]       drop_last_seq,
  output logic [2:0]        status,
  output logic [15:0]       bytes_copied,
  output logic [1:0]        availability,
  output logic              last
);
  import efq_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int LW = $clog2(MAX_PAYLOAD_BYTES + 1);
  localparam int ENW = 16 + 16 + LW + 64 + 64 + 64;
  localparam logic [16:0] DROP_SZ = 17'(HEADER_BYTES + DROP_INFO_BYTES);

  logic [4:0]  queue_limit;
  logic [3:0]  payload_limit;
  logic [15:0] drop_record_type, internal_flag_value;

  logic [AW-1:0] head_index, tail_index;
  logic [CW-1:0] stored_count;
  logic [63:0]   next_sequence, first_dropped, last_dropped;
  logic [31:0]   drops_pending;
  logic          is_closed;

  logic [2:0]  r_kind;
  logic [15:0] space, copied;
  logic [63:0] r_time;

  // effective limits
  logic [7:0]    plim;
  logic [CW-1:0] qlim;
  always_comb begin
    plim = (32'(payload_limit) < MAX_PAYLOAD_BYTES) ? 8'(payload_limit)
                                                    : 8'(MAX_PAYLOAD_BYTES);
    qlim = (queue_limit == 5'd0 || 32'(queue_limit) > DEPTH) ? CW'(DEPTH) : CW'(queue_limit);
  end

  // entry memory
  logic           we;
  logic [ENW-1:0] wdata, rdata;
  logic [63:0]    masked;
  always_comb begin
    masked = payload_word;
    for (int b = 0; b < 8; b++)
      if (b >= 32'(event_len)) masked[b*8 +: 8] = 8'd0;
  end
  assign wdata = {event_type, event_flags, event_len[LW-1:0], next_sequence, time_now, masked};

  efq_ram #(.WIDTH(ENW), .DEPTH(DEPTH)) u_ram (
    .clk(clk), .we(we), .waddr(tail_index), .wdata(wdata),
    .raddr(head_index), .rdata(rdata)
  );

  logic [15:0] e_type, e_flags;
  logic [LW-1:0] e_len;
  logic [63:0] e_seq, e_time, e_pay;
  assign {e_type, e_flags, e_len, e_seq, e_time, e_pay} = rdata;
  logic [16:0] e_sz;
  assign e_sz = 17'(HEADER_BYTES) + 17'(e_len);

  logic push_ok, push_drop, notice_drop;
  always_comb begin
    push_ok = 1'b0; push_drop = 1'b0; notice_drop = 1'b0;
    if (cmd.latch_req) begin
      if (kind == KIND_PUSH && event_len <= plim && !is_closed) begin
        if (stored_count >= qlim) push_drop = 1'b1;
        else push_ok = 1'b1;
      end
      if (kind == KIND_NOTICE && !is_closed) notice_drop = 1'b1;
    end
  end
  assign we = push_ok;

  always_comb begin
    stat.is_read     = (r_kind == KIND_READ);
    stat.space_zero  = (space == 16'd0);
    stat.has_drops   = (drops_pending != 32'd0);
    stat.has_entries = (stored_count != '0);
    stat.closed      = is_closed;
    stat.drop_fits   = (17'(space) >= DROP_SZ);
    stat.entry_fits  = (17'(space) >= e_sz);
    stat.copied_zero = (copied == 16'd0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      queue_limit <= 5'd0; payload_limit <= 4'd8;
      drop_record_type <= 16'd0; internal_flag_value <= 16'd1;
      head_index <= '0; tail_index <= '0; stored_count <= '0;
      next_sequence <= 64'd1; drops_pending <= '0;
      first_dropped <= '0; last_dropped <= '0; is_closed <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          CFG_QUEUE_LIMIT:   queue_limit <= cfg_data[4:0];
          CFG_PAYLOAD_LIMIT: payload_limit <= cfg_data[3:0];
          CFG_DROP_TYPE:     drop_record_type <= cfg_data;
          CFG_DROP_FLAGS:    internal_flag_value <= cfg_data;
          default: ;
        endcase
      end
      if (push_ok || push_drop || notice_drop) next_sequence <= next_sequence + 64'd1;
      if (push_ok) begin
        tail_index   <= (32'(tail_index) == DEPTH - 1) ? '0 : tail_index + AW'(1);
        stored_count <= stored_count + CW'(1);
      end
      if (push_drop || notice_drop) begin
        if (drops_pending == 32'd0) first_dropped <= next_sequence;
        if (drops_pending != 32'hFFFF_FFFF) drops_pending <= drops_pending + 32'd1;
        last_dropped <= next_sequence;
      end
      if (cmd.latch_req && kind == KIND_CLOSE) is_closed <= 1'b1;
      if (cmd.emit_drop) begin
        drops_pending <= '0; first_dropped <= '0; last_dropped <= '0;
      end
      if (cmd.emit_entry) begin
        head_index   <= (32'(head_index) == DEPTH - 1) ? '0 : head_index + AW'(1);
        stored_count <= stored_count - CW'(1);
      end
    end
  end

  // request capture and read bookkeeping
  always_ff @(posedge clk) begin
    if (cmd.latch_req) begin
      r_kind <= kind;
      space  <= (kind == KIND_READ) ? read_space : 16'd0;
      r_time <= time_now;
      copied <= 16'd0;
      is_record <= 1'b0;
      status <= ST_OK;
      if (kind == KIND_PUSH) begin
        if (event_len > plim) status <= ST_TOO_BIG;
        else if (is_closed) status <= ST_CLOSED;
        else if (stored_count >= qlim) status <= ST_NO_SPACE;
      end else if (kind == KIND_NOTICE && is_closed) status <= ST_CLOSED;
    end
    if (cmd.emit_drop) begin
      is_record <= 1'b1; record_type <= drop_record_type;
      record_flags <= internal_flag_value; record_len <= 8'(DROP_INFO_BYTES);
      record_seq <= first_dropped; record_time <= r_time;
      record_payload <= 64'(drops_pending); drop_last_seq <= last_dropped;
      status <= ST_OK; bytes_copied <= 16'd0; availability <= 2'd0; last <= 1'b0;
      copied <= copied + 16'(DROP_SZ); space <= space - 16'(DROP_SZ);
    end
    if (cmd.emit_entry) begin
      is_record <= 1'b1; record_type <= e_type; record_flags <= e_flags;
      record_len <= 8'(e_len); record_seq <= e_seq; record_time <= e_time;
      record_payload <= e_pay; drop_last_seq <= 64'd0;
      status <= ST_OK; bytes_copied <= 16'd0; availability <= 2'd0; last <= 1'b0;
      copied <= copied + 16'(e_sz); space <= space - 16'(e_sz);
    end
    if (cmd.emit_done) begin
      is_record <= 1'b0; record_type <= '0; record_flags <= '0; record_len <= '0;
      record_seq <= '0; record_time <= '0; record_payload <= '0; drop_last_seq <= '0;
      last <= 1'b1; bytes_copied <= copied;
      availability <= {is_closed, (drops_pending != 32'd0) || (stored_count != '0)};
      status <= ST_OK;
      if (r_kind == KIND_PUSH || r_kind == KIND_NOTICE) status <= status;
      else if (r_kind == KIND_READ && space != 16'd0) begin
        if (copied == 16'd0 && drops_pending == 32'd0 && stored_count == '0) begin
          if (!is_closed) status <= ST_WOULD_BLOCK;
        end else if (copied == 16'd0 && (drops_pending != 32'd0 ||
                     stored_count != '0)) status <= ST_SMALL;
      end
    end
  end
endmodule

// File: rtl/efq_checker.sv
`include "assert_macros.svh"

module efq_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic       is_record,
  input logic       last,
  input logic [2:0] status
);
  import efq_pkg::*;

  `CHK_IMPLY(a_rec_not_last, clk, rst, out_valid && is_record, !last, "record marked last")
  `CHK_IMPLY(a_rec_ok, clk, rst, out_valid && is_record, status == ST_OK, "record status set")
  `CHK_NEXT(a_busy_after_req, clk, rst, in_valid && !in_stall, in_stall, "second request taken")
  `CHK_IMPLY(a_out_busy, clk, rst, out_valid, in_stall, "request taken while result pending")
endmodule

bind event_fifo_with_drop_records efq_checker u_chk (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .is_record(is_record),
  .last(last), .status(status)
);
